// ===== sv/qbti_pkg.sv =====
// Shared types, constants and helpers for the timed quadratic Bezier interpolator.
package qbti_pkg;

   localparam int TIME_W     = 27;
   localparam int COUNT_W    = 7;
   localparam int COORD_W    = 32;
   localparam int EIDX_W     = 6;
   localparam int PHASE_W    = 2;
   localparam int D_W        = 29;
   localparam int P_W        = 17;
   localparam int W_W        = 33;
   localparam int MULT_W     = 2 * P_W;
   localparam int PROD_W     = 66;
   localparam int SUM_W      = 67;
   localparam int RES_W      = SUM_W - 32;
   localparam int REM_W      = 28;
   localparam int STEP_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 27;

   localparam logic signed [D_W-1:0]   HALF_DAY_MS = 29'sd43200000;
   localparam logic signed [D_W-1:0]   DAY_MS      = 29'sd86400000;
   localparam logic [P_W-1:0]          ONE_Q16     = 17'h10000;
   localparam logic signed [SUM_W-1:0] ROUND_HALF  = 67'sh80000000;
   localparam logic [STEP_W-1:0]       DIV_LAST    = 4'd15;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   localparam logic [PHASE_W-1:0] PHASE_BEFORE = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_WITHIN = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_AFTER  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAJ_COUNT = 2'd2;

   typedef struct packed {
      logic                      func;
      logic [EIDX_W-1:0]         entry_index;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] ctrl_x;
      logic signed [COORD_W-1:0] ctrl_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [TIME_W-1:0]         time_ms;
   } req_type;

   typedef struct packed {
      logic [EIDX_W-1:0]         entry_index_res;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic [PHASE_W-1:0]        phase;
      logic                      last;
   } rsp_type;

   typedef enum logic [1:0] {
      WSEL_QQ,
      WSEL_PQ,
      WSEL_PP
   } wsel_type;

   typedef struct packed {
      logic     load;
      logic     offset;
      logic     wrap;
      logic     prog;
      logic     div_step;
      logic     weight;
      wsel_type wsel;
      logic     first;
      logic     rd;
      logic     mul;
      logic     add;
      logic     sat;
      logic     next;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic n_zero;
      logic last;
   } sts_type;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [RES_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > RES_W'(64'sh7fffffff)) begin
         r = 32'sh7fffffff;
      end else if (v < -RES_W'(64'sh80000000)) begin
         r = 32'sh80000000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/qbti_ctrl.sv =====
// Sequencer for the interpolator: load, offset, divide, weights and per-entry output.
module qbti_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_func,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  qbti_pkg::sts_type sts,
   output qbti_pkg::cmd_type cmd
);
   import qbti_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_WRAP, S_PROG, S_DIV, S_WQQ, S_WPQ, S_WPP,
      S_RD, S_MUL, S_ADD, S_SAT, S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.wsel = WSEL_QQ;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.offset = 1'b1;
                  state_in   = S_WRAP;
               end
            end
         end
         S_WRAP: begin
            cmd.wrap = 1'b1;
            state_in = S_PROG;
         end
         S_PROG: begin
            cmd.prog = 1'b1;
            step_in  = '0;
            state_in = sts.need_div ? S_DIV : S_WQQ;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = S_WQQ;
            end
         end
         S_WQQ: begin
            cmd.weight = 1'b1;
            cmd.wsel   = WSEL_QQ;
            state_in   = S_WPQ;
         end
         S_WPQ: begin
            cmd.weight = 1'b1;
            cmd.wsel   = WSEL_PQ;
            state_in   = S_WPP;
         end
         S_WPP: begin
            cmd.weight = 1'b1;
            cmd.wsel   = WSEL_PP;
            cmd.first  = 1'b1;
            state_in   = sts.n_zero ? S_IDLE : S_RD;
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_SAT;
         end
         S_SAT: begin
            cmd.sat  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (sts.last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next = 1'b1;
                  state_in = S_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== sv/qbti_datapath.sv =====
// Datapath: registers, point tables, progress divider, weights and blend arithmetic.
module qbti_datapath #(
   parameter int MAX_TRAJ = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  qbti_pkg::req_type                   req_data,
   input  logic                                csr_we,
   input  logic [qbti_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qbti_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  qbti_pkg::cmd_type                   cmd,
   output qbti_pkg::sts_type                   sts,
   output qbti_pkg::rsp_type                   rsp_data
);
   import qbti_pkg::*;

   localparam int IDXW = (MAX_TRAJ > 1) ? $clog2(MAX_TRAJ) : 1;
   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_TRAJ);

   logic [TIME_W-1:0]  start_ff;
   logic [TIME_W-1:0]  dur_ff;
   logic [COUNT_W-1:0] count_ff;

   logic [2*COORD_W-1:0] s_mem [MAX_TRAJ];
   logic [2*COORD_W-1:0] c_mem [MAX_TRAJ];
   logic [2*COORD_W-1:0] e_mem [MAX_TRAJ];
   logic [2*COORD_W-1:0] s_rd_ff, c_rd_ff, e_rd_ff;

   logic signed [D_W-1:0] d_ff;
   logic [PHASE_W-1:0]    phase_ff;
   logic [P_W-1:0]        p_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [W_W-1:0]        w0_ff, w1_ff, w2_ff;
   logic [COUNT_W-1:0]    k_ff;

   logic signed [PROD_W-1:0] px0_ff, px1_ff, px2_ff, py0_ff, py1_ff, py2_ff;
   logic signed [SUM_W-1:0]  sx_ff, sy_ff;
   rsp_type                  rsp_ff;

   logic [COUNT_W-1:0]    n_eff;
   logic signed [D_W-1:0] dur_ext;
   logic [REM_W:0]        rem_sh;
   logic                  div_bit;
   logic [P_W-1:0]        q_val, mul_a, mul_b;
   logic [MULT_W-1:0]     mul_p;
   logic                  load_ok;

   assign n_eff   = (count_ff > MAX_CNT) ? MAX_CNT : count_ff;
   assign dur_ext = $signed({2'b00, dur_ff});
   assign rem_sh  = {rem_ff, 1'b0};
   assign div_bit = (rem_sh >= {2'b00, dur_ff});
   assign q_val   = ONE_Q16 - p_ff;
   assign load_ok = ({1'b0, req_data.entry_index} < MAX_CNT);

   always_comb begin
      case (cmd.wsel)
         WSEL_QQ: begin mul_a = q_val; mul_b = q_val; end
         WSEL_PQ: begin mul_a = p_ff;  mul_b = q_val; end
         WSEL_PP: begin mul_a = p_ff;  mul_b = p_ff;  end
         default: begin mul_a = q_val; mul_b = q_val; end
      endcase
      mul_p = MULT_W'(mul_a) * MULT_W'(mul_b);
   end

   assign sts.need_div = (dur_ff != '0) && (d_ff > 0) && (d_ff < dur_ext);
   assign sts.n_zero   = (n_eff == '0);
   assign sts.last     = (COUNT_W'(k_ff + 1'b1) == n_eff);
   assign rsp_data     = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         dur_ff   <= '0;
         count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_TIME: start_ff <= csr_wdata;
            CSR_DURATION:   dur_ff   <= csr_wdata;
            CSR_TRAJ_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         s_mem[req_data.entry_index[IDXW-1:0]] <= {req_data.start_y, req_data.start_x};
         c_mem[req_data.entry_index[IDXW-1:0]] <= {req_data.ctrl_y, req_data.ctrl_x};
         e_mem[req_data.entry_index[IDXW-1:0]] <= {req_data.end_y, req_data.end_x};
      end
      if (cmd.rd) begin
         s_rd_ff <= s_mem[k_ff[IDXW-1:0]];
         c_rd_ff <= c_mem[k_ff[IDXW-1:0]];
         e_rd_ff <= e_mem[k_ff[IDXW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.offset) begin
         d_ff <= $signed({2'b00, req_data.time_ms}) - $signed({2'b00, start_ff});
      end
      if (cmd.wrap) begin
         if (d_ff < -HALF_DAY_MS) begin
            d_ff <= d_ff + DAY_MS;
         end else if (d_ff > HALF_DAY_MS) begin
            d_ff <= d_ff - DAY_MS;
         end
      end
      if (cmd.prog) begin
         phase_ff <= (d_ff > dur_ext) ? PHASE_AFTER :
                     ((d_ff < 0) ? PHASE_BEFORE : PHASE_WITHIN);
         rem_ff   <= d_ff[REM_W-1:0];
         if (sts.need_div) begin
            p_ff <= '0;
         end else begin
            p_ff <= ((d_ff > 0) && (d_ff >= dur_ext)) ? ONE_Q16 : '0;
         end
      end
      if (cmd.div_step) begin
         rem_ff <= div_bit ? REM_W'(rem_sh - {2'b00, dur_ff}) : rem_sh[REM_W-1:0];
         p_ff   <= {p_ff[P_W-2:0], div_bit};
      end
      if (cmd.weight) begin
         case (cmd.wsel)
            WSEL_QQ: w0_ff <= mul_p[W_W-1:0];
            WSEL_PQ: w1_ff <= {mul_p[W_W-2:0], 1'b0};
            WSEL_PP: w2_ff <= mul_p[W_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (cmd.first) begin
         k_ff <= '0;
      end else if (cmd.next) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         px0_ff <= $signed({1'b0, w0_ff}) * $signed(s_rd_ff[COORD_W-1:0]);
         px1_ff <= $signed({1'b0, w1_ff}) * $signed(c_rd_ff[COORD_W-1:0]);
         px2_ff <= $signed({1'b0, w2_ff}) * $signed(e_rd_ff[COORD_W-1:0]);
         py0_ff <= $signed({1'b0, w0_ff}) * $signed(s_rd_ff[2*COORD_W-1:COORD_W]);
         py1_ff <= $signed({1'b0, w1_ff}) * $signed(c_rd_ff[2*COORD_W-1:COORD_W]);
         py2_ff <= $signed({1'b0, w2_ff}) * $signed(e_rd_ff[2*COORD_W-1:COORD_W]);
      end
      if (cmd.add) begin
         sx_ff <= SUM_W'(px0_ff) + SUM_W'(px1_ff) + SUM_W'(px2_ff) + ROUND_HALF;
         sy_ff <= SUM_W'(py0_ff) + SUM_W'(py1_ff) + SUM_W'(py2_ff) + ROUND_HALF;
      end
      if (cmd.sat) begin
         rsp_ff.entry_index_res <= k_ff[EIDX_W-1:0];
         rsp_ff.pos_x           <= sat_coord($signed(sx_ff[SUM_W-1:32]));
         rsp_ff.pos_y           <= sat_coord($signed(sy_ff[SUM_W-1:32]));
         rsp_ff.phase           <= phase_ff;
         rsp_ff.last            <= sts.last;
      end
   end

endmodule

// ===== sv/quadratic_bezier_timed_interpolator.sv =====
// Top level of the timed quadratic Bezier interpolator.
// Input channel req_*: a load transfer (func 0) writes the start, control and end
// points of one table entry; an evaluate transfer (func 1) gives a time of day in ms.
// Result channel rsp_*: an evaluate yields one transfer per entry in use, entries
// 0 upward, last set on the final one; a load yields nothing.
// Sequence: a load writes its entry and leaves the block idle. An evaluate first forms
// the time offset, wraps it and sets the progress; when the time falls inside the
// movement the restoring divider follows (one quotient bit per cycle); then come the
// weights (one shared 17x17 multiplier), then for each entry a table read, products,
// sum, saturation and transfer, held while the receiver stalls. req_stall is high from
// the evaluate until its final result transfers; the block handles one item at a time.
// While rsp_stall is high the result register holds its value and rsp_valid stays.
// Reset clears the sequencer and the configuration registers; the point tables
// are undefined until loaded. Configuration writes via csr_* belong between items.
module quadratic_bezier_timed_interpolator #(
   parameter int MAX_TRAJ = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  qbti_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output qbti_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [qbti_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qbti_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import qbti_pkg::*;

   cmd_type cmd;
   sts_type sts;

   qbti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_data.func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   qbti_datapath #(
      .MAX_TRAJ (MAX_TRAJ)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/qbti_checker.sv =====
// Port-level checks for the interpolator and their bind to the top level.
module qbti_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input qbti_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input qbti_pkg::rsp_type rsp_data
);
   import qbti_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !rsp_valid)
      else $error("item accepted while a result is pending");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while results are outstanding");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.func == FUNC_LOAD) |=> !rsp_valid)
      else $error("load transfer produced a result");

   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.phase == PHASE_BEFORE) ||
                     (rsp_data.phase == PHASE_WITHIN) ||
                     (rsp_data.phase == PHASE_AFTER)))
      else $error("invalid phase code");

endmodule

bind quadratic_bezier_timed_interpolator qbti_checker u_qbti_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
